// ===== hdl/fsap_pkg.sv =====
// shared types and constants of the format string argument type parser
// result descriptors, queue entries and config bundle; no dependencies
package fsap_pkg;

	// argument type codes of a result
	localparam logic [2:0] AT_INT8  = 3'd0;
	localparam logic [2:0] AT_INT16 = 3'd1;
	localparam logic [2:0] AT_INT32 = 3'd2;
	localparam logic [2:0] AT_INT64 = 3'd3;
	localparam logic [2:0] AT_DBL   = 3'd4;
	localparam logic [2:0] AT_X87   = 3'd5;
	localparam logic [2:0] AT_PTR   = 3'd6;

	// most results one character can cause
	localparam int MAX_RES = 3;

	typedef struct packed {
		logic default_int_is_64;
		logic scan_mode;
	} cfg_t;

	typedef struct packed {
		logic [2:0] arg_type;
		logic [1:0] pointer_levels;
		logic       is_end;
	} res_t;

	// one queue entry: all results caused by one character
	typedef struct packed {
		logic [1:0]               cnt;
		res_t [MAX_RES-1:0]       res;
	} entry_t;

endpackage

// ===== hdl/fsap_front.sv =====
// front part: accepts characters, runs the specifier state machine
// and pushes the results of each character as one queue entry; uses fsap_pkg
module fsap_front (
	input  logic            clk,
	input  logic            arst_n,
	input  fsap_pkg::cfg_t  cfg,
	input  logic            char_valid,
	input  logic [7:0]      char_code,
	output logic            char_stall,
	input  logic            q_full,
	output logic            push,
	output fsap_pkg::entry_t push_entry
);
	import fsap_pkg::*;

	typedef enum logic [3:0] {
		PH_TEXT, PH_PCT, PH_POSDIG, PH_FLAGS, PH_WDIG, PH_STAR, PH_STARDIG, PH_AFTERW,
		PH_DOT, PH_PDIG, PH_PSTAR, PH_PSTARDIG, PH_LEN, PH_I, PH_IDIG
	} phase_t;

	typedef struct packed {
		logic       vld;
		logic [2:0] arg;
		logic [1:0] ptr;
	} conv_t;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_TWO    = 8'h32;
	localparam logic [7:0] CH_THREE  = 8'h33;
	localparam logic [7:0] CH_FOUR   = 8'h34;
	localparam logic [7:0] CH_SIX    = 8'h36;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UC     = 8'h43;
	localparam logic [7:0] CH_UE     = 8'h45;
	localparam logic [7:0] CH_UF     = 8'h46;
	localparam logic [7:0] CH_UG     = 8'h47;
	localparam logic [7:0] CH_UI     = 8'h49;
	localparam logic [7:0] CH_UL     = 8'h4C;
	localparam logic [7:0] CH_US     = 8'h53;
	localparam logic [7:0] CH_UX     = 8'h58;
	localparam logic [7:0] CH_UZ     = 8'h5A;
	localparam logic [7:0] CH_A      = 8'h61;
	localparam logic [7:0] CH_C      = 8'h63;
	localparam logic [7:0] CH_D      = 8'h64;
	localparam logic [7:0] CH_E      = 8'h65;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_G      = 8'h67;
	localparam logic [7:0] CH_H      = 8'h68;
	localparam logic [7:0] CH_I      = 8'h69;
	localparam logic [7:0] CH_J      = 8'h6A;
	localparam logic [7:0] CH_L      = 8'h6C;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_O      = 8'h6F;
	localparam logic [7:0] CH_P      = 8'h70;
	localparam logic [7:0] CH_S      = 8'h73;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_Z      = 8'h7A;

	phase_t     phase_q, ph_d;
	logic       dn_q, dn_d;
	logic [2:0] low_q, low_d;
	logic [1:0] high_q, high_d;
	logic       stopped_q, stop_d;

	logic       accept;
	logic       is_dig, is_nul, is_zero, is_flag;
	logic [2:0] dflt;
	logic [1:0] n_pre;
	logic       tail_vld, tail_end;
	logic       go_flags, go_aft, go_len;
	conv_t      conv;
	res_t       dflt_res, tail_res;

	function automatic logic [1:0] sat_add(input logic [1:0] h, input logic [1:0] k);
		logic [2:0] s;
		s = {1'b0, h} + {1'b0, k};
		return (s > 3'd2) ? 2'd2 : s[1:0];
	endfunction

	function automatic logic [2:0] int_sel(input logic [2:0] lo, input logic [1:0] hi,
			input logic [2:0] fallback);
		logic [2:0] r;
		if (hi >= 2'd2 || lo[2])
			r = AT_INT64;
		else if (hi >= 2'd1)
			r = AT_INT32;
		else if (lo[1])
			r = AT_INT8;
		else if (lo[0])
			r = AT_INT16;
		else
			r = fallback;
		return r;
	endfunction

	function automatic conv_t convert(input logic [7:0] c, input logic [2:0] lo,
			input logic [1:0] hi, input logic [2:0] df);
		conv_t r;
		logic  big;
		big = (hi >= 2'd2) || lo[2];
		r   = '{vld: 1'b1, arg: df, ptr: 2'd0};
		unique case (c) inside
			CH_D, CH_I:                                 r.arg = int_sel(lo, hi, df);
			CH_O, CH_U, CH_X, CH_UX:                    r.arg = int_sel(lo, hi, AT_INT32);
			CH_F, CH_UF, CH_E, CH_UE, CH_G, CH_UG, CH_A, CH_UA:
			                                            r.arg = big ? AT_X87 : AT_DBL;
			CH_C, CH_UC:                                r.arg = AT_INT8;
			CH_S, CH_US: begin
				r.arg = AT_INT8;
				r.ptr = 2'd1;
			end
			CH_P:                                       r.arg = AT_PTR;
			CH_N: begin
				r.arg = int_sel(lo, hi, AT_INT32);
				r.ptr = 2'd1;
			end
			CH_PCT:                                     r.vld = 1'b0;
			default:                                    r.arg = df;
		endcase
		return r;
	endfunction

	assign char_stall = q_full;
	assign accept     = char_valid && !q_full;

	assign is_nul  = (char_code == CH_NUL);
	assign is_zero = (char_code == CH_ZERO);
	assign is_dig  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
	assign is_flag = (char_code == CH_QUOTE) || (char_code == CH_MINUS) ||
	                 (char_code == CH_PLUS) || (char_code == CH_SPACE) ||
	                 (char_code == CH_HASH) || is_zero;
	assign dflt    = cfg.default_int_is_64 ? AT_INT64 : AT_INT32;
	assign conv    = convert(char_code, low_q, high_q, dflt);

	always_comb begin
		ph_d     = phase_q;
		dn_d     = dn_q;
		low_d    = low_q;
		high_d   = high_q;
		stop_d   = stopped_q;
		n_pre    = 2'd0;
		tail_vld = 1'b0;
		tail_end = 1'b0;
		go_flags = 1'b0;
		go_aft   = 1'b0;
		go_len   = 1'b0;
		if (is_nul) begin
			// nul closes any open specifier, then the end marker, then full clear
			tail_vld = 1'b1;
			tail_end = 1'b1;
			ph_d     = PH_TEXT;
			dn_d     = 1'b0;
			low_d    = 3'd0;
			high_d   = 2'd0;
			stop_d   = 1'b0;
			if (!stopped_q) begin
				unique case (phase_q) inside
					PH_TEXT:                                      n_pre = 2'd0;
					PH_STAR, PH_PSTAR, PH_STARDIG, PH_PSTARDIG:   n_pre = 2'd2;
					default:                                      n_pre = 2'd1;
				endcase
			end
		end else if (!stopped_q) begin
			unique case (phase_q)
				PH_TEXT: begin
					if (char_code == CH_PCT) begin
						ph_d   = PH_PCT;
						low_d  = 3'd0;
						high_d = 2'd0;
					end
				end
				PH_PCT: begin
					if (is_dig) begin
						dn_d = !is_zero;
						ph_d = PH_POSDIG;
					end else
						go_flags = 1'b1;
				end
				PH_POSDIG: begin
					if (is_dig)
						dn_d = dn_q | !is_zero;
					else if (char_code == CH_DOLLAR) begin
						if (!dn_q) begin
							stop_d = 1'b1;
							ph_d   = PH_TEXT;
						end else
							ph_d = PH_FLAGS;
					end else if (dn_q)
						go_aft = 1'b1;
					else
						go_flags = 1'b1;
				end
				PH_STARDIG, PH_PSTARDIG: begin
					if (is_dig)
						dn_d = dn_q | !is_zero;
					else if (char_code == CH_DOLLAR) begin
						if (!dn_q) begin
							stop_d = 1'b1;
							ph_d   = PH_TEXT;
						end else begin
							n_pre = 2'd1;
							ph_d  = (phase_q == PH_STARDIG) ? PH_AFTERW : PH_LEN;
						end
					end else begin
						// star then digits without '$': star and first digit both consume
						n_pre  = 2'd2;
						low_d  = 3'd0;
						high_d = 2'd0;
						ph_d   = (char_code == CH_PCT) ? PH_PCT : PH_TEXT;
					end
				end
				PH_FLAGS:  go_flags = 1'b1;
				PH_WDIG:   go_aft = !is_dig;
				PH_PDIG:   go_len = !is_dig;
				PH_STAR: begin
					if (is_dig) begin
						dn_d = !is_zero;
						ph_d = PH_STARDIG;
					end else begin
						n_pre  = 2'd1;
						go_aft = 1'b1;
					end
				end
				PH_PSTAR: begin
					if (is_dig) begin
						dn_d = !is_zero;
						ph_d = PH_PSTARDIG;
					end else begin
						n_pre  = 2'd1;
						go_len = 1'b1;
					end
				end
				PH_AFTERW: go_aft = 1'b1;
				PH_DOT: begin
					if (char_code == CH_STAR)
						ph_d = PH_PSTAR;
					else if (is_dig)
						ph_d = PH_PDIG;
					else
						go_len = 1'b1;
				end
				PH_I: begin
					if (char_code == CH_THREE || char_code == CH_SIX)
						ph_d = PH_IDIG;
					else
						go_len = 1'b1;
				end
				PH_IDIG: begin
					if (char_code == CH_TWO)
						high_d = sat_add(high_q, 2'd1);
					else if (char_code == CH_FOUR)
						high_d = sat_add(high_q, 2'd2);
					ph_d = PH_LEN;
				end
				default:   go_len = 1'b1;
			endcase

			if (go_flags) begin
				if (is_flag)
					ph_d = PH_FLAGS;
				else if (char_code == CH_STAR)
					ph_d = PH_STAR;
				else if (is_dig)
					ph_d = PH_WDIG;
				else
					go_aft = 1'b1;
			end
			if (go_aft) begin
				if (char_code == CH_DOT)
					ph_d = PH_DOT;
				else
					go_len = 1'b1;
			end
			if (go_len) begin
				ph_d = PH_LEN;
				unique case (char_code) inside
					CH_H:        low_d = low_q | (low_q[0] ? 3'b010 : 3'b001);
					CH_UL:       low_d = low_q | 3'b100;
					CH_L:        high_d = sat_add(high_q, 2'd1);
					CH_UI:       ph_d = PH_I;
					CH_J, CH_Z, CH_UZ:
					             high_d = sat_add(high_q, 2'd2);
					CH_T:        high_d = sat_add(high_q, cfg.default_int_is_64 ? 2'd2 : 2'd1);
					default: begin
						tail_vld = conv.vld;
						low_d    = 3'd0;
						high_d   = 2'd0;
						ph_d     = PH_TEXT;
					end
				endcase
			end
		end
	end

	assign dflt_res = '{arg_type: dflt, pointer_levels: {1'b0, cfg.scan_mode}, is_end: 1'b0};
	assign tail_res = tail_end ? '{arg_type: AT_INT8, pointer_levels: 2'd0, is_end: 1'b1}
	                           : '{arg_type: conv.arg,
	                               pointer_levels: conv.ptr + {1'b0, cfg.scan_mode},
	                               is_end: 1'b0};

	always_comb begin
		push_entry.cnt = n_pre + {1'b0, tail_vld};
		for (int i = 0; i < MAX_RES; i++)
			push_entry.res[i] = (2'(i) < n_pre) ? dflt_res : tail_res;
	end

	assign push = accept && (push_entry.cnt != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_TEXT;
			dn_q      <= 1'b0;
			low_q     <= 3'd0;
			high_q    <= 2'd0;
			stopped_q <= 1'b0;
		end else if (accept) begin
			phase_q   <= ph_d;
			dn_q      <= dn_d;
			low_q     <= low_d;
			high_q    <= high_d;
			stopped_q <= stop_d;
		end
	end

endmodule

// ===== hdl/fsap_queue.sv =====
// result queue between front and back parts; one entry per character
// that causes results; uses fsap_pkg
module fsap_queue #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  fsap_pkg::entry_t push_entry,
	output logic             full,
	input  logic             pop,
	output logic             head_vld,
	output fsap_pkg::entry_t head
);
	import fsap_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	entry_t        mem [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full     = (count_q == CW'(DEPTH));
	assign head_vld = (count_q != '0);
	assign head     = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== hdl/fsap_back.sv =====
// back part: walks the results of the head queue entry one per cycle
// into the output register while res_stall is low; uses fsap_pkg
module fsap_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_vld,
	input  fsap_pkg::entry_t head,
	output logic             pop,
	output logic             res_valid,
	input  logic             res_stall,
	output fsap_pkg::res_t   res,
	output logic             res_last
);
	import fsap_pkg::*;

	logic [1:0] idx_q;
	logic       valid_q;
	res_t       res_q;
	logic       last_q;
	logic       load, is_last;

	assign load    = !valid_q || !res_stall;
	assign is_last = (idx_q == head.cnt - 2'd1);
	assign pop     = load && head_vld && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (load) begin
			valid_q <= head_vld;
			if (head_vld)
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && head_vld) begin
			res_q  <= head.res[idx_q];
			last_q <= is_last;
		end
	end

	assign res_valid = valid_q;
	assign res       = res_q;
	assign res_last  = last_q;

endmodule

// ===== hdl/format_string_arg_type_parser.sv =====
// an accepted character's results are written as one entry into the result queue and
// then pass from the queue head into the output register
// throughput: one character per cycle; results leave one per cycle from the output register
// while res_stall is low, and char_stall rises while the QUEUE_DEPTH-entry result queue is full
// reset: arst_n clears parse state, queue pointers, output valid and both config
// registers at once; no clearing pass, the block takes characters right after reset
module format_string_arg_type_parser #(
	parameter int QUEUE_DEPTH = 4   // queue entries, 2 or more
) (
	input  logic       clk,
	input  logic       arst_n,
	// character channel
	input  logic       char_valid,
	output logic       char_stall,
	input  logic [7:0] char_code,
	// configuration write channel
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic       cfg_data,
	// result channel
	output logic       res_valid,
	input  logic       res_stall,
	output logic [2:0] arg_type,
	output logic [1:0] pointer_levels,
	output logic       is_end,
	output logic       last
);
	import fsap_pkg::*;

	// register indexes of the configuration port
	localparam logic CFG_DEFAULT_INT = 1'b0;
	localparam logic CFG_SCAN        = 1'b1;

	cfg_t   cfg_q;
	logic   q_full, push, pop, head_vld;
	entry_t push_entry, head;
	res_t   res;

	// config writes never stall; the user must issue them only while the block is idle, the block does not enforce it
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_DEFAULT_INT: cfg_q.default_int_is_64 <= cfg_data;
				CFG_SCAN:        cfg_q.scan_mode         <= cfg_data;
			endcase
		end
	end

	// front: decodes each character against the specifier state and builds
	// the full result list of that character in the same cycle
	fsap_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.char_valid (char_valid),
		.char_code  (char_code),
		.char_stall (char_stall),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	// characters that cause no result never enter the queue
	fsap_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head_vld   (head_vld),
		.head       (head)
	);

	// back: up to three results per entry, the last one flagged
	fsap_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_vld  (head_vld),
		.head      (head),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.res_last  (last)
	);

	assign arg_type       = res.arg_type;
	assign pointer_levels = res.pointer_levels;
	assign is_end         = res.is_end;

endmodule

// ===== hdl/fsap_checker.sv =====
// port-level checks of the format string argument type parser
// bound to the top level below; uses fsap_pkg
module fsap_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_stall,
	input logic [2:0] arg_type,
	input logic [1:0] pointer_levels,
	input logic       is_end,
	input logic       last
);
	import fsap_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid &&
			$stable({arg_type, pointer_levels, is_end, last}))
		else $error("result changed while stalled");

	a_end_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && is_end |-> last && arg_type == AT_INT8 && pointer_levels == 2'd0)
		else $error("end marker malformed or not last");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> arg_type <= AT_PTR && pointer_levels <= 2'd2)
		else $error("result code out of range");

	a_two_levels: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && pointer_levels == 2'd2 |-> arg_type <= AT_INT64)
		else $error("two pointer levels on a non-integer type");

endmodule

bind format_string_arg_type_parser fsap_checker u_fsap_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (res_valid),
	.res_stall      (res_stall),
	.arg_type       (arg_type),
	.pointer_levels (pointer_levels),
	.is_end         (is_end),
	.last           (last)
);

// ===== bench/format_string_arg_type_parser_test.sv =====
// self-checking bench of the format string argument type parser: directed and random
// format strings, own parser prediction, random idling on both channels
// depends on fsap_pkg and format_string_arg_type_parser
module format_string_arg_type_parser_test;
	import fsap_pkg::*;

	// config register indexes
	localparam logic REG_DEFAULT_INT64 = 1'b0;
	localparam logic REG_SCAN_MODE     = 1'b1;

	localparam logic [7:0] NUL_CHAR   = 8'h00;
	localparam logic [7:0] DIGIT_ZERO = 8'h30;

	localparam int ITEM_GOAL    = 430;
	localparam int DRAIN_CYCLES = 8;   // covers the output register with margin
	localparam int MAX_WAIT     = 6;
	localparam int MAX_REPORTS  = 10;

	// where the parser stands inside a conversion specifier
	typedef enum logic [3:0] {
		S_TEXT, S_PERCENT, S_POS_DIGITS, S_FLAGS, S_WIDTH_DIGITS, S_STAR, S_STAR_DIGITS,
		S_AFTER_WIDTH, S_DOT, S_PREC_DIGITS, S_PREC_STAR, S_PREC_STAR_DIGITS, S_LENGTH,
		S_I, S_I_DIGIT
	} spec_phase_t;

	// one expected result item
	typedef struct packed {
		res_t res;
		logic last;
	} arg_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       char_valid = 1'b0;
	logic       char_stall;
	logic [7:0] char_code = 8'h00;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_index = 1'b0;
	logic       cfg_data = 1'b0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic [2:0] arg_type;
	logic [1:0] pointer_levels;
	logic       is_end;
	logic       last;

	format_string_arg_type_parser u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.char_valid     (char_valid),
		.char_stall     (char_stall),
		.char_code      (char_code),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.arg_type       (arg_type),
		.pointer_levels (pointer_levels),
		.is_end         (is_end),
		.last           (last)
	);

	always #2 clk = ~clk;

	// parser prediction state, mirrors the block after each accepted char
	spec_phase_t spec_phase;
	logic        pos_nonzero;     // some digit of the current index was nonzero
	logic [2:0]  len_bits;        // h, hh and L flags
	logic [1:0]  len_weight;      // l/I32/I64/j/z/Z/t weight in units of 32 bits, saturating
	logic        parse_halted;    // zero positional index seen, wait for NUL
	cfg_t        model_cfg;

	res_t        char_results[$];    // results of the char being predicted
	arg_result_t expected_args[$];   // results still to come from the block
	logic [7:0]  pending_chars[$];   // chars not yet presented
	arg_result_t want_arg;

	int  chars_sent = 0;
	int  chars_taken = 0;
	int  planned_items = 0;
	int  mismatches = 0;
	int  char_gap = 0;
	int  res_gap = 0;
	logic quiet_run = 1'b0;          // no idling on either side

	string flag_chars = "'-+ #0";
	string conv_letters = "diouxXfFeEgGaAcCsSpn%qk";
	string length_mods [18] = '{"", "", "", "h", "hh", "hhh", "L", "l", "ll", "lll", "I32",
		"I64", "j", "z", "Z", "t", "I6", "I5"};

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic [2:0] default_int();
		return model_cfg.default_int_is_64 ? AT_INT64 : AT_INT32;
	endfunction

	// integer type picked by the length modifiers seen so far
	function automatic logic [2:0] int_width(input logic [2:0] fallback);
		if (len_weight >= 2'd2 || len_bits[2])
			return AT_INT64;
		if (len_weight >= 2'd1)
			return AT_INT32;
		if (len_bits[1])
			return AT_INT8;
		if (len_bits[0])
			return AT_INT16;
		return fallback;
	endfunction

	task automatic clear_spec();
		spec_phase = S_TEXT;
		pos_nonzero = 1'b0;
		len_bits = 3'd0;
		len_weight = 2'd0;
		parse_halted = 1'b0;
	endtask

	// one char causes at most MAX_RES results; scan mode adds a pointer level
	task automatic emit_arg(input logic [2:0] kind, input logic [1:0] ptr, input logic end_mark);
		res_t r;
		if (char_results.size() < MAX_RES) begin
			r.arg_type = kind;
			r.pointer_levels = end_mark ? 2'd0 : ptr + {1'b0, model_cfg.scan_mode};
			r.is_end = end_mark;
			char_results.insert(char_results.size(), r);
		end
	endtask

	task automatic add_weight(input int k);
		int v;
		v = len_weight + k;
		len_weight = (v > 2) ? 2'd2 : 2'(v);
	endtask

	task automatic convert_letter(input logic [7:0] c);
		logic wide;
		wide = (len_weight >= 2'd2) || len_bits[2];
		case (c)
			"d", "i": emit_arg(int_width(default_int()), 2'd0, 1'b0);
			"o", "u", "x", "X": emit_arg(int_width(AT_INT32), 2'd0, 1'b0);
			"f", "F", "e", "E", "g", "G", "a", "A": emit_arg(wide ? AT_X87 : AT_DBL, 2'd0, 1'b0);
			"c", "C": emit_arg(AT_INT8, 2'd0, 1'b0);
			"s", "S": emit_arg(AT_INT8, 2'd1, 1'b0);
			"p": emit_arg(AT_PTR, 2'd0, 1'b0);
			"n": emit_arg(int_width(AT_INT32), 2'd1, 1'b0);
			"%": ;
			default: emit_arg(default_int(), 2'd0, 1'b0);
		endcase
	endtask

	// predict the results of one accepted char and queue them
	task automatic parse_char(input logic [7:0] c);
		spec_phase_t ph;
		logic        redo;
		arg_result_t entry;
		int          i;
		char_results.delete();
		if (parse_halted) begin
			// halted: only NUL does something
			if (c == NUL_CHAR) begin
				emit_arg(AT_INT8, 2'd0, 1'b1);
				clear_spec();
			end
		end else begin
			ph = spec_phase;
			redo = 1'b1;
			while (redo) begin
				redo = 1'b0;
				case (ph)
					S_TEXT: begin
						if (c == NUL_CHAR) begin
							emit_arg(AT_INT8, 2'd0, 1'b1);
							clear_spec();
							ph = S_TEXT;
						end else if (c == "%") begin
							ph = S_PERCENT;
							len_bits = 3'd0;
							len_weight = 2'd0;
						end
					end
					S_PERCENT: begin
						if (is_digit(c)) begin
							pos_nonzero = (c != "0");
							ph = S_POS_DIGITS;
						end else begin
							ph = S_FLAGS;
							redo = 1'b1;
						end
					end
					S_POS_DIGITS, S_STAR_DIGITS, S_PREC_STAR_DIGITS: begin
						if (is_digit(c)) begin
							if (c != "0")
								pos_nonzero = 1'b1;
						end else if (c == "$") begin
							if (!pos_nonzero) begin
								// zero index halts the parse
								parse_halted = 1'b1;
								ph = S_TEXT;
							end else if (ph == S_POS_DIGITS) begin
								ph = S_FLAGS;
							end else begin
								emit_arg(default_int(), 2'd0, 1'b0);
								ph = (ph == S_STAR_DIGITS) ? S_AFTER_WIDTH : S_LENGTH;
							end
						end else if (ph == S_POS_DIGITS) begin
							// digits were flags and width after all
							ph = pos_nonzero ? S_AFTER_WIDTH : S_FLAGS;
							redo = 1'b1;
						end else begin
							// star with digits but no dollar: star and first digit both consume
							emit_arg(default_int(), 2'd0, 1'b0);
							emit_arg(default_int(), 2'd0, 1'b0);
							len_bits = 3'd0;
							len_weight = 2'd0;
							ph = S_TEXT;
							redo = 1'b1;
						end
					end
					S_FLAGS: begin
						if (c == "'" || c == "-" || c == "+" || c == " " || c == "#" || c == "0")
							ph = S_FLAGS;
						else if (c == "*")
							ph = S_STAR;
						else if (is_digit(c))
							ph = S_WIDTH_DIGITS;
						else begin
							ph = S_AFTER_WIDTH;
							redo = 1'b1;
						end
					end
					S_WIDTH_DIGITS, S_PREC_DIGITS: begin
						if (!is_digit(c)) begin
							ph = (ph == S_WIDTH_DIGITS) ? S_AFTER_WIDTH : S_LENGTH;
							redo = 1'b1;
						end
					end
					S_STAR, S_PREC_STAR: begin
						if (is_digit(c)) begin
							pos_nonzero = (c != "0");
							ph = (ph == S_STAR) ? S_STAR_DIGITS : S_PREC_STAR_DIGITS;
						end else begin
							emit_arg(default_int(), 2'd0, 1'b0);
							ph = (ph == S_STAR) ? S_AFTER_WIDTH : S_LENGTH;
							redo = 1'b1;
						end
					end
					S_AFTER_WIDTH: begin
						if (c == ".")
							ph = S_DOT;
						else begin
							ph = S_LENGTH;
							redo = 1'b1;
						end
					end
					S_DOT: begin
						if (c == "*")
							ph = S_PREC_STAR;
						else if (is_digit(c))
							ph = S_PREC_DIGITS;
						else begin
							ph = S_LENGTH;
							redo = 1'b1;
						end
					end
					S_I: begin
						if (c == "3" || c == "6")
							ph = S_I_DIGIT;
						else begin
							ph = S_LENGTH;
							redo = 1'b1;
						end
					end
					S_I_DIGIT: begin
						// any byte but NUL is swallowed here
						if (c == NUL_CHAR) begin
							ph = S_LENGTH;
							redo = 1'b1;
						end else begin
							if (c == "2")
								add_weight(1);
							else if (c == "4")
								add_weight(2);
							ph = S_LENGTH;
						end
					end
					default: begin
						if (c == "h") begin
							if (len_bits[0])
								len_bits[1] = 1'b1;
							else
								len_bits[0] = 1'b1;
						end else if (c == "L")
							len_bits[2] = 1'b1;
						else if (c == "l")
							add_weight(1);
						else if (c == "I")
							ph = S_I;
						else if (c == "j" || c == "z" || c == "Z")
							add_weight(2);
						else if (c == "t")
							add_weight(model_cfg.default_int_is_64 ? 2 : 1);
						else begin
							// conversion letter; NUL here also ends the string
							convert_letter(c);
							len_bits = 3'd0;
							len_weight = 2'd0;
							ph = S_TEXT;
							if (c == NUL_CHAR)
								redo = 1'b1;
						end
					end
				endcase
			end
			spec_phase = ph;
		end
		for (i = 0; i < char_results.size(); i++) begin
			entry.res = char_results[i];
			entry.last = (i == char_results.size() - 1);
			expected_args.insert(expected_args.size(), entry);
		end
	endtask

	// char driver: one item at a time, random gap before each next item
	always @(posedge clk) begin
		if (!arst_n) begin
			char_valid <= 1'b0;
			char_gap = 0;
		end else begin
			if (char_valid && !char_stall) begin
				parse_char(char_code);
				chars_taken++;
			end
			// a stalled item stays put
			if (!char_valid || !char_stall) begin
				if (char_gap > 0) begin
					char_gap--;
					char_valid <= 1'b0;
				end else if (pending_chars.size() > 0) begin
					char_code <= pending_chars.pop_front();
					char_valid <= 1'b1;
					char_gap = quiet_run ? 0 : $urandom_range(0, MAX_WAIT);
				end else begin
					char_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: check against the oldest expectation, then maybe stall a while
	always @(posedge clk) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			res_gap = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_args.size() == 0) begin
					if (mismatches < MAX_REPORTS)
						$display("unexpected result: type %0d ptr %0d end %0b last %0b",
							arg_type, pointer_levels, is_end, last);
					mismatches++;
				end else begin
					want_arg = expected_args.pop_front();
					if (arg_type !== want_arg.res.arg_type ||
						pointer_levels !== want_arg.res.pointer_levels ||
						is_end !== want_arg.res.is_end || last !== want_arg.last) begin
						if (mismatches < MAX_REPORTS)
							$display({"result mismatch: expected type %0d ptr %0d end %0b last %0b,",
								" got type %0d ptr %0d end %0b last %0b"},
								want_arg.res.arg_type, want_arg.res.pointer_levels,
								want_arg.res.is_end, want_arg.last,
								arg_type, pointer_levels, is_end, last);
						mismatches++;
					end
				end
				res_gap = quiet_run ? 0 : $urandom_range(0, MAX_WAIT);
			end
			if (res_gap > 0) begin
				res_gap--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	// stimulus helpers; every queued char counts as one item
	task automatic push_item(input logic [7:0] c);
		pending_chars.insert(pending_chars.size(), c);
		chars_sent++;
		planned_items++;
	endtask

	task automatic push_string(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			push_item(s[i]);
	endtask

	task automatic push_number();
		repeat ($urandom_range(1, 2))
			push_item(DIGIT_ZERO + 8'($urandom_range(0, 9)));
	endtask

	task automatic add_text();
		repeat ($urandom_range(0, 3))
			push_item(8'($urandom_range(32, 126)));
	endtask

	// one conversion specifier with random parts
	task automatic add_spec();
		int pick;
		push_item("%");
		// positional index, sometimes all zeros
		if ($urandom_range(0, 4) == 0) begin
			push_number();
			push_item("$");
		end
		repeat ($urandom_range(0, 2))
			push_item(flag_chars[$urandom_range(0, flag_chars.len() - 1)]);
		// width: none, digits, star, star with index, star with bare digits
		pick = $urandom_range(0, 6);
		if (pick == 3)
			push_number();
		else if (pick >= 4) begin
			push_item("*");
			if (pick >= 5)
				push_number();
			if (pick == 5)
				push_item("$");
		end
		// precision
		if ($urandom_range(0, 2) == 0) begin
			push_item(".");
			pick = $urandom_range(0, 5);
			if (pick == 1 || pick == 2)
				push_number();
			else if (pick >= 3) begin
				push_item("*");
				if (pick >= 4)
					push_number();
				if (pick == 4)
					push_item("$");
			end
		end
		push_string(length_mods[$urandom_range(0, 17)]);
		push_item(conv_letters[$urandom_range(0, conv_letters.len() - 1)]);
	endtask

	// one NUL-terminated string: mostly well formed, some cut short, some raw noise
	task automatic add_string();
		int kind;
		int mark;
		int cut;
		kind = $urandom_range(0, 9);
		if (kind < 7) begin
			repeat ($urandom_range(1, 3)) begin
				add_text();
				add_spec();
			end
			add_text();
		end else if (kind < 9) begin
			mark = pending_chars.size();
			add_spec();
			cut = $urandom_range(1, pending_chars.size() - mark - 1);
			repeat (cut) begin
				void'(pending_chars.pop_back());
				chars_sent--;
				planned_items--;
			end
		end else begin
			repeat ($urandom_range(1, 8))
				push_item(8'($urandom_range(0, 255)));
		end
		push_item(NUL_CHAR);
	endtask

	// both registers back to back, valid held high across the two writes
	task automatic set_config(input logic wide_int, input logic scan);
		cfg_valid <= 1'b1;
		cfg_index <= REG_DEFAULT_INT64;
		cfg_data <= wide_int;
		do @(posedge clk); while (!cfg_ready);
		model_cfg.default_int_is_64 = wide_int;
		cfg_index <= REG_SCAN_MODE;
		cfg_data <= scan;
		do @(posedge clk); while (!cfg_ready);
		model_cfg.scan_mode = scan;
		cfg_valid <= 1'b0;
	endtask

	// wait for all chars taken and all results back, then let the pipe empty
	task automatic drain();
		while (chars_taken != chars_sent || expected_args.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int p;
		int goal;
		clear_spec();
		model_cfg = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_config(1'b0, 1'b0);

		// directed strings
		// star with digits but no dollar
		push_string("%*12x");
		push_item(NUL_CHAR);
		// zero positional index halts until NUL
		push_string("%00$d");
		push_item(NUL_CHAR);
		// NUL inside a specifier
		push_string("%l");
		push_item(NUL_CHAR);
		// NUL right after I3
		push_string("%I3");
		push_item(NUL_CHAR);
		// top byte value as an unknown conversion letter
		push_item("%");
		push_item(8'hFF);
		push_item(NUL_CHAR);
		// percent conversion consumes nothing
		push_string("%%");
		push_item(NUL_CHAR);
		drain();

		// random phases, each with its own config; third one without idling
		for (p = 0; p < 4; p++) begin
			case (p)
				0: set_config(1'b1, 1'b0);
				1: set_config(1'b0, 1'b1);
				2: set_config(1'b1, 1'b1);
				default: set_config(1'b0, 1'b0);
			endcase
			quiet_run = (p == 2);
			goal = (ITEM_GOAL * (p + 1)) / 4;
			while (planned_items < goal)
				add_string();
			drain();
		end

		if (mismatches == 0 && expected_args.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// run limit
	initial begin
		#1000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
